/* design/tiled_matmul_sequencer_unit_defines.svh */
// Assertion macros shared by the tiled matmul sequencer RTL
`ifndef TILED_MATMUL_SEQUENCER_UNIT_DEFINES_SVH
`define TILED_MATMUL_SEQUENCER_UNIT_DEFINES_SVH

// same-cycle implication
`define TMM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TMM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/tmm_pkg.sv */
// Package: types, constants and helpers for the tiled matmul sequencer
`timescale 1ns / 1ps
`default_nettype none

package tmm_pkg;

   localparam int ADDR_W        = 16;
   localparam int DATA_W        = 32;
   localparam int SIZE_W        = 9;
   localparam int CSR_DATA_W    = 16;
   localparam int CSR_INDEX_W   = 2;
   localparam int TILE_DIM      = 4;
   localparam int TILE_IDX_W    = 2;
   localparam int TILE_ELEMS    = 16;
   localparam int STEP_W        = 4;
   localparam int TILE_LAST     = 15;
   localparam int EXEC_ACC_STEP = 5;
   localparam int EXEC_LAST_STEP = 8;
   localparam int PHASE_CODE_W  = 3;
   localparam int SIZE_RESET    = 4;

   typedef enum logic [5:0] {
      PHASE_IDLE   = 6'b000001,
      PHASE_ADDR   = 6'b000010,
      PHASE_LOAD_A = 6'b000100,
      PHASE_LOAD_B = 6'b001000,
      PHASE_EXEC   = 6'b010000,
      PHASE_WB     = 6'b100000
   } phase_type;

   typedef enum logic [PHASE_CODE_W-1:0] {
      PHASE_CODE_IDLE   = 3'd0,
      PHASE_CODE_ADDR   = 3'd1,
      PHASE_CODE_LOAD_A = 3'd2,
      PHASE_CODE_LOAD_B = 3'd3,
      PHASE_CODE_EXEC   = 3'd4,
      PHASE_CODE_WB     = 3'd5
   } phase_code_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MATRIX_SIZE = 2'd0,
      CSR_BASE_A      = 2'd1,
      CSR_BASE_B      = 2'd2,
      CSR_BASE_C      = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ADDR_SEL_HOLD = 3'd0,
      ADDR_SEL_NEXT = 3'd1,
      ADDR_SEL_A    = 3'd2,
      ADDR_SEL_B    = 3'd3,
      ADDR_SEL_C    = 3'd4
   } addr_sel_type;

   typedef struct packed {
      logic              load_a;
      logic              accum;
      logic              clear;
      logic              exec;
      logic [STEP_W-1:0] step;
   } tile_ctrl_type;

   function automatic phase_code_type phase_code(input phase_type ph);
      phase_code_type code;
      case (ph)
         PHASE_ADDR:   code = PHASE_CODE_ADDR;
         PHASE_LOAD_A: code = PHASE_CODE_LOAD_A;
         PHASE_LOAD_B: code = PHASE_CODE_LOAD_B;
         PHASE_EXEC:   code = PHASE_CODE_EXEC;
         PHASE_WB:     code = PHASE_CODE_WB;
         default:      code = PHASE_CODE_IDLE;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

/* design/tmm_addr_gen.sv */
// Address generator: tile start addresses and in-tile address stepping
`timescale 1ns / 1ps
`default_nettype none

module tmm_addr_gen import tmm_pkg::*; #(
   parameter int TILE_W = 7
) (
   input  addr_sel_type        sel,
   input  logic [ADDR_W-1:0]   cur_address,
   input  logic [SIZE_W-1:0]   matrix_size,
   input  logic [ADDR_W-1:0]   base_a,
   input  logic [ADDR_W-1:0]   base_b,
   input  logic [ADDR_W-1:0]   base_c,
   input  logic [TILE_W-1:0]   tile_row,
   input  logic [TILE_W-1:0]   tile_col,
   input  logic [TILE_W-1:0]   tile_depth,
   input  logic [STEP_W-1:0]   step,
   output logic [ADDR_W-1:0]   next_address
);

   logic [ADDR_W-1:0]        base_sel;
   logic [TILE_W-1:0]        r_sel;
   logic [TILE_W-1:0]        c_sel;
   logic [TILE_W+SIZE_W-1:0] row_prod;
   logic [ADDR_W-1:0]        tile_start;
   logic [ADDR_W-1:0]        step_address;

   always_comb begin
      base_sel = base_a;
      r_sel    = tile_row;
      c_sel    = tile_depth;
      case (sel)
         ADDR_SEL_B: begin
            base_sel = base_b;
            r_sel    = tile_depth;
            c_sel    = tile_col;
         end
         ADDR_SEL_C: begin
            base_sel = base_c;
            r_sel    = tile_row;
            c_sel    = tile_col;
         end
         default: begin
            base_sel = base_a;
            r_sel    = tile_row;
            c_sel    = tile_depth;
         end
      endcase
   end

   assign row_prod   = r_sel * matrix_size;
   assign tile_start = base_sel + ADDR_W'({row_prod, 2'b00}) + ADDR_W'({c_sel, 2'b00});

   // end of a tile row jumps to the next matrix row
   assign step_address = (step[TILE_IDX_W-1:0] == TILE_IDX_W'(TILE_DIM - 1))
      ? cur_address + ADDR_W'(matrix_size) - ADDR_W'(TILE_DIM - 1)
      : cur_address + ADDR_W'(1);

   always_comb begin
      case (sel)
         ADDR_SEL_NEXT: next_address = step_address;
         ADDR_SEL_A,
         ADDR_SEL_B,
         ADDR_SEL_C:    next_address = tile_start;
         default:       next_address = cur_address;
      endcase
   end

endmodule

`default_nettype wire

/* design/tmm_tile_buf.sv */
// Tile buffer: A tile storage with skewed feed and C tile accumulators
`timescale 1ns / 1ps
`default_nettype none

module tmm_tile_buf import tmm_pkg::*; (
   input  logic                                clock,
   input  logic                                reset,
   input  tile_ctrl_type                       ctrl,
   input  logic [DATA_W-1:0]                   read_word,
   input  logic [TILE_DIM-1:0][DATA_W-1:0]     result_cols,
   output logic [TILE_DIM-1:0][DATA_W-1:0]     feed,
   output logic [DATA_W-1:0]                   sum_word
);

   // a_col_ff[col][row]
   logic [DATA_W-1:0] a_col_ff [TILE_DIM][TILE_DIM];
   logic [DATA_W-1:0] sum_ff [TILE_ELEMS];
   logic [STEP_W-1:0] acc_step;
   logic [TILE_IDX_W-1:0] acc_row;

   always_ff @(posedge clock) begin
      if (ctrl.load_a) begin
         a_col_ff[ctrl.step[TILE_IDX_W-1:0]][ctrl.step[STEP_W-1:TILE_IDX_W]] <= read_word;
      end
   end

   generate
      for (genvar gc = 0; gc < TILE_DIM; gc++) begin : g_feed
         logic [STEP_W-1:0] diff;
         assign diff = ctrl.step - STEP_W'(gc);
         assign feed[gc] = (ctrl.exec && ctrl.step >= STEP_W'(gc) &&
                            diff < STEP_W'(TILE_DIM))
                           ? a_col_ff[gc][diff[TILE_IDX_W-1:0]] : '0;
      end
   endgenerate

   // result row for this execute step
   assign acc_step = ctrl.step - STEP_W'(1);
   assign acc_row  = acc_step[TILE_IDX_W-1:0];

   always_ff @(posedge clock) begin
      for (int e = 0; e < TILE_ELEMS; e++) begin
         if (reset || ctrl.clear) begin
            sum_ff[e] <= '0;
         end else if (ctrl.accum && TILE_IDX_W'(e / TILE_DIM) == acc_row) begin
            sum_ff[e] <= sum_ff[e] + result_cols[e % TILE_DIM];
         end
      end
   end

   assign sum_word = sum_ff[ctrl.step];

endmodule

`default_nettype wire

/* design/tiled_matmul_sequencer_unit.sv */
// Top level: tiled matmul sequencer with config registers and result register
//
// Usage:
//   Every accepted req_ request is one controller tick: start flag, the memory
//   read data for the address of the previous tick and the four array result
//   columns. Each request yields exactly one rsp_ response carrying the memory
//   address and write strobe/data, the four skewed A feeds, the weight write
//   and the phase of that tick.
//   The response is registered: a request accepted shows on rsp_ in the next
//   cycle. Throughput is one request per cycle while the receiver takes each
//   response; the whole tick is one pass of control logic plus one 7x9 address
//   multiply between the state registers and the response register.
//   csr_ writes set matrix size and the A, B, C base addresses; csr_ready is
//   always high and writes are meant for times with no request in flight.
//   Reset returns the controller to idle, clears counters and sums, loads
//   matrix size 4 and zero bases, and drops rsp_valid.
//   When the receiver stalls, the held response stays put and req_ready is low
//   until it is taken; in the cycle it is taken a new request may enter.
//
`timescale 1ns / 1ps
`default_nettype none

`include "tiled_matmul_sequencer_unit_defines.svh"

module tiled_matmul_sequencer_unit import tmm_pkg::*; #(
   parameter int MAX_TILES = 64
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_start_req,
   input  logic signed [DATA_W-1:0]  req_read_word,
   input  logic signed [DATA_W-1:0]  req_result_col0,
   input  logic signed [DATA_W-1:0]  req_result_col1,
   input  logic signed [DATA_W-1:0]  req_result_col2,
   input  logic signed [DATA_W-1:0]  req_result_col3,

   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [ADDR_W-1:0]         rsp_mem_address,
   output logic                      rsp_mem_write_enable,
   output logic signed [DATA_W-1:0]  rsp_mem_write_data,
   output logic signed [DATA_W-1:0]  rsp_feed0,
   output logic signed [DATA_W-1:0]  rsp_feed1,
   output logic signed [DATA_W-1:0]  rsp_feed2,
   output logic signed [DATA_W-1:0]  rsp_feed3,
   output logic                      rsp_weight_valid,
   output logic [STEP_W-1:0]         rsp_weight_slot,
   output logic signed [DATA_W-1:0]  rsp_weight_value,
   output logic [PHASE_CODE_W-1:0]   rsp_phase,

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_write_data
);

   localparam int TILE_CAP = (MAX_TILES < 127) ? MAX_TILES : 127;
   localparam int TILE_W   = $clog2(TILE_CAP + 1);

   // configuration
   logic [SIZE_W-1:0] size_ff;
   logic [ADDR_W-1:0] base_a_ff;
   logic [ADDR_W-1:0] base_b_ff;
   logic [ADDR_W-1:0] base_c_ff;

   // controller state
   phase_type         phase_ff, phase_in;
   logic [TILE_W-1:0] row_ff, row_in;
   logic [TILE_W-1:0] col_ff, col_in;
   logic [TILE_W-1:0] depth_ff, depth_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [ADDR_W-1:0] cur_ff;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]         rsp_addr_ff, rsp_addr_in;
   logic                      rsp_we_ff, rsp_we_in;
   logic [DATA_W-1:0]         rsp_wdata_ff, rsp_wdata_in;
   logic [TILE_DIM-1:0][DATA_W-1:0] rsp_feed_ff;
   logic                      rsp_wvalid_ff, rsp_wvalid_in;
   logic [STEP_W-1:0]         rsp_wslot_ff, rsp_wslot_in;
   logic [DATA_W-1:0]         rsp_wvalue_ff, rsp_wvalue_in;
   logic [PHASE_CODE_W-1:0]   rsp_phase_ff;

   logic                      req_accept;
   logic                      step_last;
   logic [TILE_W-1:0]         num_tiles;
   logic [TILE_W:0]           nt_ext;
   logic [TILE_W:0]           depth_inc;
   logic [TILE_W:0]           col_inc;
   logic [TILE_W:0]           row_inc;
   logic [TILE_W:0]           row_after;
   logic [SIZE_W-3:0]         tiles_raw;
   addr_sel_type              addr_sel;
   logic [ADDR_W-1:0]         addr_next;
   tile_ctrl_type             tile_ctrl;
   logic [TILE_DIM-1:0][DATA_W-1:0] result_cols;
   logic [TILE_DIM-1:0][DATA_W-1:0] feed;
   logic [DATA_W-1:0]         sum_word;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= SIZE_W'(SIZE_RESET);
         base_a_ff <= '0;
         base_b_ff <= '0;
         base_c_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MATRIX_SIZE: size_ff   <= csr_write_data[SIZE_W-1:0];
            CSR_BASE_A:      base_a_ff <= csr_write_data;
            CSR_BASE_B:      base_b_ff <= csr_write_data;
            CSR_BASE_C:      base_c_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // tiles per dimension, capped
   assign tiles_raw = size_ff[SIZE_W-1:2];
   assign num_tiles = (int'(tiles_raw) > MAX_TILES) ? TILE_W'(MAX_TILES)
                                                    : TILE_W'(tiles_raw);
   assign nt_ext    = {1'b0, num_tiles};
   assign depth_inc = {1'b0, depth_ff} + (TILE_W+1)'(1);
   assign col_inc   = {1'b0, col_ff} + (TILE_W+1)'(1);
   assign row_inc   = {1'b0, row_ff} + (TILE_W+1)'(1);
   assign row_after = (col_inc >= nt_ext) ? row_inc : {1'b0, row_ff};
   assign step_last = (step_ff == STEP_W'(TILE_LAST));

   always_comb begin
      phase_in      = phase_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      depth_in      = depth_ff;
      step_in       = step_ff;
      addr_sel      = ADDR_SEL_HOLD;
      rsp_we_in     = 1'b0;
      rsp_wdata_in  = '0;
      rsp_wvalid_in = 1'b0;
      rsp_wslot_in  = '0;
      rsp_wvalue_in = '0;
      case (phase_ff)
         PHASE_ADDR: begin
            addr_sel = ADDR_SEL_A;
            step_in  = '0;
            phase_in = PHASE_LOAD_A;
         end
         PHASE_LOAD_A: begin
            if (step_last) begin
               addr_sel = ADDR_SEL_B;
               step_in  = '0;
               phase_in = PHASE_LOAD_B;
            end else begin
               addr_sel = ADDR_SEL_NEXT;
               step_in  = step_ff + STEP_W'(1);
            end
         end
         PHASE_LOAD_B: begin
            // weights go out transposed
            rsp_wvalid_in = 1'b1;
            rsp_wslot_in  = {step_ff[TILE_IDX_W-1:0], step_ff[STEP_W-1:TILE_IDX_W]};
            rsp_wvalue_in = req_read_word;
            if (step_last) begin
               addr_sel = ADDR_SEL_C;
               step_in  = '0;
               phase_in = PHASE_EXEC;
            end else begin
               addr_sel = ADDR_SEL_NEXT;
               step_in  = step_ff + STEP_W'(1);
            end
         end
         PHASE_EXEC: begin
            if (step_ff >= STEP_W'(EXEC_LAST_STEP)) begin
               step_in = '0;
               if (depth_inc >= nt_ext) begin
                  addr_sel = ADDR_SEL_C;
                  phase_in = PHASE_WB;
               end else begin
                  depth_in = depth_inc[TILE_W-1:0];
                  phase_in = PHASE_ADDR;
               end
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         PHASE_WB: begin
            rsp_we_in    = 1'b1;
            rsp_wdata_in = sum_word;
            if (step_last) begin
               col_in   = (col_inc >= nt_ext) ? '0 : col_inc[TILE_W-1:0];
               row_in   = row_after[TILE_W-1:0];
               depth_in = '0;
               step_in  = '0;
               phase_in = (row_after >= nt_ext) ? PHASE_IDLE : PHASE_ADDR;
            end else begin
               addr_sel = ADDR_SEL_NEXT;
               step_in  = step_ff + STEP_W'(1);
            end
         end
         default: begin
            row_in   = '0;
            col_in   = '0;
            depth_in = '0;
            step_in  = '0;
            phase_in = req_start_req ? PHASE_ADDR : PHASE_IDLE;
         end
      endcase
   end

   tmm_addr_gen #(
      .TILE_W (TILE_W)
   ) u_addr_gen (
      .sel          (addr_sel),
      .cur_address  (cur_ff),
      .matrix_size  (size_ff),
      .base_a       (base_a_ff),
      .base_b       (base_b_ff),
      .base_c       (base_c_ff),
      .tile_row     (row_ff),
      .tile_col     (col_ff),
      .tile_depth   (depth_ff),
      .step         (step_ff),
      .next_address (addr_next)
   );

   assign tile_ctrl.load_a = req_accept && (phase_ff == PHASE_LOAD_A);
   assign tile_ctrl.accum  = req_accept && (phase_ff == PHASE_EXEC) &&
                             (step_ff >= STEP_W'(EXEC_ACC_STEP));
   assign tile_ctrl.clear  = req_accept && (phase_ff == PHASE_WB) && step_last;
   assign tile_ctrl.exec   = (phase_ff == PHASE_EXEC);
   assign tile_ctrl.step   = step_ff;

   assign result_cols[0] = req_result_col0;
   assign result_cols[1] = req_result_col1;
   assign result_cols[2] = req_result_col2;
   assign result_cols[3] = req_result_col3;

   tmm_tile_buf u_tile_buf (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (tile_ctrl),
      .read_word   (req_read_word),
      .result_cols (result_cols),
      .feed        (feed),
      .sum_word    (sum_word)
   );

   // writeback shows the address before stepping
   assign rsp_addr_in  = (phase_ff == PHASE_WB) ? cur_ff : addr_next;
   assign rsp_valid_in = req_accept ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         row_ff   <= '0;
         col_ff   <= '0;
         depth_ff <= '0;
         step_ff  <= '0;
         cur_ff   <= '0;
      end else if (req_accept) begin
         phase_ff <= phase_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         depth_ff <= depth_in;
         step_ff  <= step_in;
         cur_ff   <= addr_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_addr_ff   <= rsp_addr_in;
         rsp_we_ff     <= rsp_we_in;
         rsp_wdata_ff  <= rsp_wdata_in;
         rsp_feed_ff   <= feed;
         rsp_wvalid_ff <= rsp_wvalid_in;
         rsp_wslot_ff  <= rsp_wslot_in;
         rsp_wvalue_ff <= rsp_wvalue_in;
         rsp_phase_ff  <= phase_code(phase_ff);
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_mem_address      = rsp_addr_ff;
   assign rsp_mem_write_enable = rsp_we_ff;
   assign rsp_mem_write_data   = rsp_wdata_ff;
   assign rsp_feed0            = rsp_feed_ff[0];
   assign rsp_feed1            = rsp_feed_ff[1];
   assign rsp_feed2            = rsp_feed_ff[2];
   assign rsp_feed3            = rsp_feed_ff[3];
   assign rsp_weight_valid     = rsp_wvalid_ff;
   assign rsp_weight_slot      = rsp_wslot_ff;
   assign rsp_weight_value     = rsp_wvalue_ff;
   assign rsp_phase            = rsp_phase_ff;

   `TMM_ASSERT_NOW(a_no_overrun, clock, reset, rsp_valid_ff && !rsp_ready, !req_ready, "request taken over a stalled response")
   `TMM_ASSERT_NEXT(a_wb_strobe, clock, reset, req_accept && phase_ff == PHASE_WB, rsp_valid_ff && rsp_we_ff, "writeback tick without write strobe")
   `TMM_ASSERT_NOW(a_exec_step, clock, reset, phase_ff == PHASE_EXEC, step_ff <= STEP_W'(EXEC_LAST_STEP), "execute step out of range")
   `TMM_ASSERT_NEXT(a_start, clock, reset, req_accept && phase_ff == PHASE_IDLE && req_start_req, phase_ff == PHASE_ADDR, "start request did not leave idle")

endmodule

`default_nettype wire

/* dv/tiled_matmul_sequencer_unit_checker.sv */
// Checker for the tiled matmul sequencer: predicts every tick and compares each response
`timescale 1ns / 1ps

module tiled_matmul_sequencer_unit_checker import tmm_pkg::*; #(
   parameter int MAX_TILES = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic                     req_start_req,
   input  logic [DATA_W-1:0]        req_read_word,
   input  logic [DATA_W-1:0]        req_result_col0,
   input  logic [DATA_W-1:0]        req_result_col1,
   input  logic [DATA_W-1:0]        req_result_col2,
   input  logic [DATA_W-1:0]        req_result_col3,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [ADDR_W-1:0]        rsp_mem_address,
   input  logic                     rsp_mem_write_enable,
   input  logic [DATA_W-1:0]        rsp_mem_write_data,
   input  logic [DATA_W-1:0]        rsp_feed0,
   input  logic [DATA_W-1:0]        rsp_feed1,
   input  logic [DATA_W-1:0]        rsp_feed2,
   input  logic [DATA_W-1:0]        rsp_feed3,
   input  logic                     rsp_weight_valid,
   input  logic [STEP_W-1:0]        rsp_weight_slot,
   input  logic [DATA_W-1:0]        rsp_weight_value,
   input  logic [PHASE_CODE_W-1:0]  rsp_phase,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_write_data,
   output int                       failures,
   output int                       pending
);

   typedef struct packed {
      logic [ADDR_W-1:0]       mem_address;
      logic                    write_enable;
      logic [DATA_W-1:0]       write_data;
      logic [3:0][DATA_W-1:0]  feeds;
      logic                    weight_valid;
      logic [STEP_W-1:0]       weight_slot;
      logic [DATA_W-1:0]       weight_value;
      logic [PHASE_CODE_W-1:0] phase;
   } tick_out_type;

   logic [SIZE_W-1:0] size_reg;
   logic [ADDR_W-1:0] base_a_reg, base_b_reg, base_c_reg;
   phase_code_type    phase_q;
   logic [6:0]        row_q, col_q, depth_q;
   logic [4:0]        step_q;
   logic [ADDR_W-1:0] addr_q;
   logic [DATA_W-1:0] a_blk [TILE_ELEMS];
   logic [DATA_W-1:0] partial_blk [TILE_ELEMS];
   logic [DATA_W-1:0] sum_blk [TILE_ELEMS];
   tick_out_type      expected_q [$];

   function automatic void clear_model();
      size_reg = SIZE_W'(SIZE_RESET);
      base_a_reg = '0;
      base_b_reg = '0;
      base_c_reg = '0;
      phase_q = PHASE_CODE_IDLE;
      row_q = '0;
      col_q = '0;
      depth_q = '0;
      step_q = '0;
      addr_q = '0;
      for (int i = 0; i < TILE_ELEMS; i++) begin
         a_blk[i] = '0;
         partial_blk[i] = '0;
         sum_blk[i] = '0;
      end
   endfunction

   function automatic int unsigned tiles_per_dim();
      int unsigned t;
      t = size_reg / TILE_DIM;
      return (t > MAX_TILES) ? MAX_TILES : t;
   endfunction

   function automatic logic [ADDR_W-1:0] tile_base(input logic [ADDR_W-1:0] base,
                                                   input int unsigned r, input int unsigned c);
      int unsigned sum;
      sum = base + 4 * r * size_reg + 4 * c;
      return sum[ADDR_W-1:0];
   endfunction

   // row stride jump after the fourth element of a tile row
   function automatic logic [ADDR_W-1:0] next_in_tile(input logic [ADDR_W-1:0] addr,
                                                      input int unsigned s);
      int unsigned sum;
      if (s[1:0] == 2'd3) sum = addr + size_reg - 3;
      else sum = addr + 1;
      return sum[ADDR_W-1:0];
   endfunction

   function automatic tick_out_type sequencer_step(input logic start,
                                                   input logic [DATA_W-1:0] rd,
                                                   input logic [3:0][DATA_W-1:0] cols);
      tick_out_type o;
      int unsigned  nt, s, t, c, i;
      o = '0;
      nt = tiles_per_dim();
      s = step_q & 15;
      o.phase = phase_q;
      case (phase_q)
         PHASE_CODE_ADDR: begin
            addr_q = tile_base(base_a_reg, row_q, depth_q);
            step_q = '0;
            phase_q = PHASE_CODE_LOAD_A;
         end
         PHASE_CODE_LOAD_A: begin
            a_blk[s] = rd;
            if (s == TILE_LAST) begin
               addr_q = tile_base(base_b_reg, depth_q, col_q);
               step_q = '0;
               phase_q = PHASE_CODE_LOAD_B;
            end else begin
               addr_q = next_in_tile(addr_q, s);
               step_q = 5'(s + 1);
            end
         end
         PHASE_CODE_LOAD_B: begin
            o.weight_valid = 1'b1;
            o.weight_slot = {s[1:0], s[3:2]};
            o.weight_value = rd;
            if (s == TILE_LAST) begin
               addr_q = tile_base(base_c_reg, row_q, col_q);
               step_q = '0;
               phase_q = PHASE_CODE_EXEC;
            end else begin
               addr_q = next_in_tile(addr_q, s);
               step_q = 5'(s + 1);
            end
         end
         PHASE_CODE_EXEC: begin
            t = step_q;
            for (c = 0; c < 4; c++)
               if (t >= c && t - c < 4) o.feeds[c] = a_blk[((t - c) << 2) | c];
            if (t >= EXEC_ACC_STEP)
               for (c = 0; c < 4; c++) partial_blk[(((t - 1) & 3) << 2) | c] = cols[c];
            if (t >= EXEC_LAST_STEP) begin
               for (i = 0; i < TILE_ELEMS; i++) sum_blk[i] = sum_blk[i] + partial_blk[i];
               step_q = '0;
               if (depth_q + 1 >= nt) begin
                  addr_q = tile_base(base_c_reg, row_q, col_q);
                  phase_q = PHASE_CODE_WB;
               end else begin
                  depth_q = 7'(depth_q + 1);
                  phase_q = PHASE_CODE_ADDR;
               end
            end else begin
               step_q = 5'(t + 1);
            end
         end
         PHASE_CODE_WB: begin
            o.write_enable = 1'b1;
            o.write_data = sum_blk[s];
            o.mem_address = addr_q;
            if (s == TILE_LAST) begin
               col_q = 7'(col_q + 1);
               if (col_q >= nt) begin
                  col_q = '0;
                  row_q = 7'(row_q + 1);
               end
               for (i = 0; i < TILE_ELEMS; i++) begin
                  partial_blk[i] = '0;
                  sum_blk[i] = '0;
               end
               step_q = '0;
               depth_q = '0;
               if (row_q >= nt) phase_q = PHASE_CODE_IDLE;
               else phase_q = PHASE_CODE_ADDR;
            end else begin
               addr_q = next_in_tile(addr_q, s);
               step_q = 5'(s + 1);
            end
         end
         default: begin
            o.phase = PHASE_CODE_IDLE;
            row_q = '0;
            col_q = '0;
            depth_q = '0;
            step_q = '0;
            if (start) phase_q = PHASE_CODE_ADDR;
            else phase_q = PHASE_CODE_IDLE;
         end
      endcase
      if (!o.write_enable) o.mem_address = addr_q;
      return o;
   endfunction

   task automatic check_field(input string field, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         failures++;
         if (failures <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      tick_out_type want;
      if (reset) begin
         clear_model();
         expected_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               failures++;
               if (failures <= 10) $display("%0t: response with no request pending", $time);
            end else begin
               want = expected_q.pop_front();
               check_field("mem_address", rsp_mem_address, want.mem_address);
               check_field("mem_write_enable", rsp_mem_write_enable, want.write_enable);
               check_field("mem_write_data", rsp_mem_write_data, want.write_data);
               check_field("feed0", rsp_feed0, want.feeds[0]);
               check_field("feed1", rsp_feed1, want.feeds[1]);
               check_field("feed2", rsp_feed2, want.feeds[2]);
               check_field("feed3", rsp_feed3, want.feeds[3]);
               check_field("weight_valid", rsp_weight_valid, want.weight_valid);
               check_field("weight_slot", rsp_weight_slot, want.weight_slot);
               check_field("weight_value", rsp_weight_value, want.weight_value);
               check_field("phase", rsp_phase, want.phase);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_MATRIX_SIZE: size_reg = csr_write_data[SIZE_W-1:0];
               CSR_BASE_A:      base_a_reg = csr_write_data;
               CSR_BASE_B:      base_b_reg = csr_write_data;
               CSR_BASE_C:      base_c_reg = csr_write_data;
               default:         ;
            endcase
         end
         if (req_valid && req_ready)
            expected_q.push_back(sequencer_step(req_start_req, req_read_word,
               {req_result_col3, req_result_col2, req_result_col1, req_result_col0}));
      end
      pending = expected_q.size();
   end

endmodule

/* dv/tiled_matmul_sequencer_unit_test.sv */
// Testbench top for the tiled matmul sequencer: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tiled_matmul_sequencer_unit_test import tmm_pkg::*; ();

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_start_req = 1'b0;
   logic [DATA_W-1:0]        req_read_word = '0;
   logic [DATA_W-1:0]        req_result_col0 = '0;
   logic [DATA_W-1:0]        req_result_col1 = '0;
   logic [DATA_W-1:0]        req_result_col2 = '0;
   logic [DATA_W-1:0]        req_result_col3 = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [ADDR_W-1:0]        rsp_mem_address;
   logic                     rsp_mem_write_enable;
   logic [DATA_W-1:0]        rsp_mem_write_data;
   logic [DATA_W-1:0]        rsp_feed0, rsp_feed1, rsp_feed2, rsp_feed3;
   logic                     rsp_weight_valid;
   logic [STEP_W-1:0]        rsp_weight_slot;
   logic [DATA_W-1:0]        rsp_weight_value;
   logic [PHASE_CODE_W-1:0]  rsp_phase;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_write_data = '0;
   int                       failures;
   int                       pending;
   int                       idle_pct = 0;
   int                       stall_pct = 0;

   tiled_matmul_sequencer_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_start_req(req_start_req),
      .req_read_word(req_read_word),
      .req_result_col0(req_result_col0), .req_result_col1(req_result_col1),
      .req_result_col2(req_result_col2), .req_result_col3(req_result_col3),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_mem_address(rsp_mem_address), .rsp_mem_write_enable(rsp_mem_write_enable),
      .rsp_mem_write_data(rsp_mem_write_data),
      .rsp_feed0(rsp_feed0), .rsp_feed1(rsp_feed1), .rsp_feed2(rsp_feed2),
      .rsp_feed3(rsp_feed3),
      .rsp_weight_valid(rsp_weight_valid), .rsp_weight_slot(rsp_weight_slot),
      .rsp_weight_value(rsp_weight_value), .rsp_phase(rsp_phase),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   tiled_matmul_sequencer_unit_checker result_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_start_req(req_start_req),
      .req_read_word(req_read_word),
      .req_result_col0(req_result_col0), .req_result_col1(req_result_col1),
      .req_result_col2(req_result_col2), .req_result_col3(req_result_col3),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_mem_address(rsp_mem_address), .rsp_mem_write_enable(rsp_mem_write_enable),
      .rsp_mem_write_data(rsp_mem_write_data),
      .rsp_feed0(rsp_feed0), .rsp_feed1(rsp_feed1), .rsp_feed2(rsp_feed2),
      .rsp_feed3(rsp_feed3),
      .rsp_weight_valid(rsp_weight_valid), .rsp_weight_slot(rsp_weight_slot),
      .rsp_weight_value(rsp_weight_value), .rsp_phase(rsp_phase),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .failures(failures), .pending(pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) rsp_ready <= !reset && ($urandom_range(0, 99) >= stall_pct);

   function automatic logic [DATA_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_tick(input logic start, input logic [DATA_W-1:0] word,
                            input logic [DATA_W-1:0] c0, c1, c2, c3);
      req_valid <= 1'b1;
      req_start_req <= start;
      req_read_word <= word;
      req_result_col0 <= c0;
      req_result_col1 <= c1;
      req_result_col2 <= c2;
      req_result_col3 <= c3;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic random_tick();
      if ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < idle_pct);
      end
      send_tick($urandom_range(0, 3) != 0, pick_word(), pick_word(), pick_word(),
                pick_word(), pick_word());
   endtask

   // hold requests until every response is back
   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic run_phase(input logic [SIZE_W-1:0] size, input logic [ADDR_W-1:0] a, b, c,
                            input int send_idle, input int recv_stall, input int count,
                            input bit pause_mid);
      drain();
      write_csr(CSR_MATRIX_SIZE, {7'($urandom), size});
      write_csr(CSR_BASE_A, a);
      write_csr(CSR_BASE_B, b);
      write_csr(CSR_BASE_C, c);
      csr_valid <= 1'b0;
      idle_pct = send_idle;
      stall_pct = recv_stall;
      for (int i = 0; i < count; i++) begin
         if (pause_mid && i == count / 2) drain();
         random_tick();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // size 4 from reset: idle, start, A and B loads, starts ignored while busy
      for (int i = 0; i < 25; i++)
         send_tick(i == 1 || (i > 2 && i[0]), pick_word(), 32'h8000_0000, 32'h7FFF_FFFF,
                   32'hFFFF_FFFF, 32'h0000_0000);
      for (int i = 0; i < 180; i++) random_tick();
      run_phase(9'd256, 16'hFFFF, 16'hFFFF, 16'hFFFF, 86, 0, 205, 1'b0);
      run_phase(9'd8, 16'h0100, 16'h8000, 16'hFFF0, 0, 86, 205, 1'b0);
      run_phase(9'd0, 16'($urandom), 16'($urandom), 16'($urandom), 17, 17, 205, 1'b0);
      run_phase(9'd3, 16'($urandom), 16'($urandom), 16'($urandom), 0, 0, 205, 1'b0);
      run_phase(9'd6, 16'($urandom), 16'($urandom), 16'($urandom), 86, 0, 205, 1'b0);
      run_phase(9'h1FF, 16'h0000, 16'h0000, 16'h0000, 0, 86, 205, 1'b0);
      run_phase(9'd4, 16'($urandom), 16'($urandom), 16'($urandom), 17, 17, 205, 1'b1);
      run_phase(9'd12, 16'($urandom), 16'($urandom), 16'($urandom), 0, 0, 205, 1'b0);
      drain();
      repeat (4) @(negedge clock);
      if (failures == 0 && pending == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
